>>> rtl/core/canonical_kmer_hash_counter_assert.svh
`ifndef CANONICAL_KMER_HASH_COUNTER_ASSERT_SVH
`define CANONICAL_KMER_HASH_COUNTER_ASSERT_SVH

// implication checked at every edge outside reset
`define CKHC_ASSERT_IMP(lbl, clk_s, rstn_s, a, c) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (a) |-> (c)) \
    else $error("ckhc assertion failed");

// check in the cycle after the antecedent, reset not masked
`define CKHC_ASSERT_NEXT(lbl, clk_s, a, c) \
  lbl: assert property (@(posedge clk_s) (a) |=> (c)) \
    else $error("ckhc assertion failed");

`endif

>>> rtl/core/ckhc_pkg.sv
package ckhc_pkg;

  localparam int TABLE_DEPTH_DEF = 65536;
  localparam int PROBE_LIMIT_DEF = 128;
  localparam int COUNT_BITS_DEF  = 32;

  localparam int KEY_W = 62;

  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [1:0] LINE_SEQ = 2'd1;
  localparam logic [0:0] REG_KMER_LENGTH = 1'b0;
  localparam logic [4:0] KMER_LENGTH_RST = 5'd21;
  localparam logic [4:0] BASES_MAX = 5'd31;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_NEW     = 2'd1,
    ST_INCR    = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_of_file;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [61:0] kmer_hash;
    logic [31:0] hit_count;
    logic [16:0] unique_count;
  } out_t;

  // item handed from front to back
  typedef struct packed {
    logic             have;
    logic [KEY_W-1:0] hash;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // bit 2 set: not a base
  function automatic logic [2:0] base_code(input logic [7:0] ch);
    case (ch)
      "A", "a":           base_code = 3'd0;
      "C", "c":           base_code = 3'd1;
      "G", "g":           base_code = 3'd2;
      "T", "t", "U", "u": base_code = 3'd3;
      default:            base_code = 3'd4;
    endcase
  endfunction

endpackage

>>> rtl/core/canonical_kmer_hash_counter.sv
// Canonical k-mer counter over a FASTQ byte stream.
// Input: one byte per command; an item is taken when start is high and
// busy is low. first_of_file restarts the record-line parser.
// Output: one result per item, shown for exactly one cycle with out_valid.
// There is no backpressure: the consumer must take every result.
// Config: kmer_length at byte address 0 through the APB port, write only
// while idle. Reads return the register.
// Front: parser, windows, then min select and a 7-step hash, one step a
// cycle; a byte with no k-mer goes straight to the queue push.
// Back: each probe is a registered table read plus a check. When
// TABLE_DEPTH is not a power of two, a k-mer first has its bucket
// remainder computed.
// A two-entry queue between front and back lets them overlap.
// After reset the table valid bits are swept clear, one entry a cycle:
// busy stays high until the sweep is done.
module canonical_kmer_hash_counter #(
  parameter int TABLE_DEPTH = ckhc_pkg::TABLE_DEPTH_DEF,
  parameter int PROBE_LIMIT = ckhc_pkg::PROBE_LIMIT_DEF,
  parameter int COUNT_BITS  = ckhc_pkg::COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  ckhc_pkg::in_t  in_data,
  output logic           out_valid,
  output ckhc_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import ckhc_pkg::*;

  logic [4:0] kmer_length_r, kmer_length_nxt;
  logic       q_push, q_pop, front_busy, clearing;
  qent_t      q_wdata, q_rdata;
  qstat_t     q_stat;

  assign pready = 1'b1;

  always_comb begin
    kmer_length_nxt = kmer_length_r;
    if (psel && penable && pwrite && (paddr[2] == REG_KMER_LENGTH))
      kmer_length_nxt = pwdata[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_length_r <= KMER_LENGTH_RST;
    end else begin
      kmer_length_r <= kmer_length_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_KMER_LENGTH) ? {27'd0, kmer_length_r} : 32'd0;
  assign busy   = front_busy || clearing;

  ckhc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start && !busy),
    .in_data     (in_data),
    .kmer_length (kmer_length_r),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_wdata     (q_wdata),
    .front_busy  (front_busy)
  );

  ckhc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  ckhc_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PROBE_LIMIT (PROBE_LIMIT),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/ckhc_front.sv
module ckhc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ckhc_pkg::in_t     in_data,
  input  logic [4:0]        kmer_length,
  input  ckhc_pkg::qstat_t  q_stat,
  output logic              q_push,
  output ckhc_pkg::qent_t   q_wdata,
  output logic              front_busy
);
  import ckhc_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_CANON, F_HASH, F_PUSH} fstate_t;

  fstate_t          state_r, state_nxt;
  logic [KEY_W-1:0] fwd_r, fwd_nxt, rev_r, rev_nxt, v_r, v_nxt, kmask_r, kmask_nxt;
  logic [4:0]       bases_r, bases_nxt;
  logic [1:0]       line_r, line_nxt;
  logic [2:0]       step_r, step_nxt;
  logic             have_r, have_nxt;

  logic [4:0]       k_eff;
  logic [5:0]       k2, rshift;
  logic [KEY_W-1:0] kmask;
  logic [2:0]       code;

  function automatic logic [KEY_W-1:0] mix_step(input logic [2:0] s,
                                                input logic [KEY_W-1:0] v,
                                                input logic [KEY_W-1:0] m);
    case (s)
      3'd0:    mix_step = (~v + (v << 21)) & m;
      3'd1:    mix_step = v ^ (v >> 24);
      3'd2:    mix_step = (v + (v << 3) + (v << 8)) & m;
      3'd3:    mix_step = v ^ (v >> 14);
      3'd4:    mix_step = (v + (v << 2) + (v << 4)) & m;
      3'd5:    mix_step = v ^ (v >> 28);
      default: mix_step = (v + (v << 31)) & m;
    endcase
  endfunction

  assign k_eff  = (kmer_length == 5'd0) ? 5'd1 : kmer_length;
  assign k2     = {k_eff, 1'b0};
  assign rshift = {k_eff - 5'd1, 1'b0};
  assign kmask  = {KEY_W{1'b1}} >> (6'(KEY_W) - k2);
  assign code   = base_code(in_data.text_byte);

  always_comb begin
    state_nxt = state_r;
    fwd_nxt   = fwd_r;
    rev_nxt   = rev_r;
    bases_nxt = bases_r;
    line_nxt  = line_r;
    v_nxt     = v_r;
    kmask_nxt = kmask_r;
    step_nxt  = step_r;
    have_nxt  = have_r;
    q_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          if (in_data.first_of_file) begin
            fwd_nxt   = '0;
            rev_nxt   = '0;
            bases_nxt = '0;
            line_nxt  = '0;
          end
          have_nxt  = 1'b0;
          kmask_nxt = kmask;
          if (in_data.text_byte == CHAR_LF) begin
            if (line_nxt == LINE_SEQ) begin
              fwd_nxt   = '0;
              rev_nxt   = '0;
              bases_nxt = '0;
            end
            line_nxt = line_nxt + 2'd1;
          end else if (line_nxt == LINE_SEQ) begin
            if (!code[2]) begin
              fwd_nxt = ((fwd_nxt << 2) | KEY_W'(code[1:0])) & kmask;
              rev_nxt = (rev_nxt >> 2) | (KEY_W'(2'd3 - code[1:0]) << rshift);
              if (bases_nxt < BASES_MAX) bases_nxt = bases_nxt + 5'd1;
              have_nxt = (bases_nxt >= k_eff);
            end else begin
              fwd_nxt   = '0;
              rev_nxt   = '0;
              bases_nxt = '0;
            end
          end
          v_nxt     = '0;
          state_nxt = have_nxt ? F_CANON : F_PUSH;
        end
      end
      F_CANON: begin
        v_nxt     = (fwd_r < rev_r) ? fwd_r : rev_r;
        step_nxt  = '0;
        state_nxt = F_HASH;
      end
      F_HASH: begin
        v_nxt    = mix_step(step_r, v_r, kmask_r);
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd6) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      fwd_r   <= '0;
      rev_r   <= '0;
      bases_r <= '0;
      line_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fwd_r   <= fwd_nxt;
      rev_r   <= rev_nxt;
      bases_r <= bases_nxt;
      line_r  <= line_nxt;
    end
    v_r     <= v_nxt;
    kmask_r <= kmask_nxt;
    step_r  <= step_nxt;
    have_r  <= have_nxt;
  end

  assign q_wdata.have = have_r;
  assign q_wdata.hash = v_r;
  assign front_busy   = (state_r != F_IDLE);

endmodule

>>> rtl/core/ckhc_queue.sv
module ckhc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ckhc_pkg::qent_t   wdata,
  input  logic              pop,
  output ckhc_pkg::qent_t   rdata,
  output ckhc_pkg::qstat_t  stat
);
  import ckhc_pkg::*;

  qent_t      slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = ~wp_r;
    if (pop)  rp_nxt = ~rp_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) slot_r[wp_r] <= wdata;
  end

  assign rdata      = slot_r[rp_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

endmodule

>>> rtl/core/ckhc_back.sv
module ckhc_back #(
  parameter int TABLE_DEPTH = ckhc_pkg::TABLE_DEPTH_DEF,
  parameter int PROBE_LIMIT = ckhc_pkg::PROBE_LIMIT_DEF,
  parameter int COUNT_BITS  = ckhc_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ckhc_pkg::qent_t   q_rdata,
  input  ckhc_pkg::qstat_t  q_stat,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_valid,
  output ckhc_pkg::out_t    out_data
);
  import ckhc_pkg::*;

  localparam int  AW   = $clog2(TABLE_DEPTH);
  localparam int  PW   = $clog2(PROBE_LIMIT + 1);
  localparam int  TW   = AW + 8;
  localparam bit  POW2 = (TABLE_DEPTH == (1 << AW));
  localparam logic [AW-1:0] LAST    = AW'(TABLE_DEPTH - 1);
  localparam logic [TW-1:0] DEPTH_T = TW'(TABLE_DEPTH);
  // floor(2^32 / depth): quotient estimate is exact or one low
  localparam logic [63:0]   RECIP   = 64'((64'd1 << 32) / TABLE_DEPTH);

  typedef struct packed {
    logic                  valid;
    logic [KEY_W-1:0]      key;
    logic [COUNT_BITS-1:0] cnt;
  } entry_t;

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_REDUCE, B_READ, B_CHECK} bstate_t;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;

  bstate_t          state_r, state_nxt;
  logic [KEY_W-1:0] hash_r, hash_nxt;
  logic [AW-1:0]    bkt_r, bkt_nxt;
  logic [AW-1:0]    rem_r, rem_nxt;
  logic [3:0]       rstep_r, rstep_nxt;
  logic [TW-1:0]    tq_r, tq_nxt;
  logic [7:0]       q_r, q_nxt;
  logic [PW-1:0]    probe_r, probe_nxt;
  logic [16:0]      uniq_r, uniq_nxt;
  logic             ov_r, ov_nxt;
  out_t             out_r, out_nxt;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_wa;
  entry_t                mem_wd;
  logic [COUNT_BITS-1:0] cnt_inc;

  logic [63:0]   hash_pad;
  logic [7:0]    digit;
  logic [TW-1:0] t_cur, t_qd, t_rem;
  logic [63:0]   t_prod;

  // remainder one hash byte at a time, top byte first: estimate, then correct
  assign hash_pad = {2'b00, hash_r};
  assign digit    = hash_pad[{~rstep_r[3:1], 3'b000} +: 8];
  assign t_cur    = {rem_r, digit};
  assign t_prod   = 64'(t_cur) * RECIP;
  assign t_qd     = TW'(q_r) * DEPTH_T;
  assign t_rem    = tq_r - t_qd;

  assign cnt_inc = (rd_q.cnt == {COUNT_BITS{1'b1}}) ? rd_q.cnt : rd_q.cnt + 1'b1;

  always_comb begin
    state_nxt = state_r;
    hash_nxt  = hash_r;
    bkt_nxt   = bkt_r;
    rem_nxt   = rem_r;
    rstep_nxt = rstep_r;
    tq_nxt    = tq_r;
    q_nxt     = q_r;
    probe_nxt = probe_r;
    uniq_nxt  = uniq_r;
    ov_nxt    = 1'b0;
    out_nxt   = out_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wa    = bkt_r;
    mem_wd    = '0;
    case (state_r)
      B_CLEAR: begin
        mem_we  = 1'b1;
        bkt_nxt = bkt_r + 1'b1;
        if (bkt_r == LAST) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          hash_nxt  = q_rdata.hash;
          probe_nxt = '0;
          if (!q_rdata.have) begin
            ov_nxt  = 1'b1;
            out_nxt = '{ST_NONE, '0, '0, uniq_r};
          end else if (POW2) begin
            bkt_nxt   = q_rdata.hash[AW-1:0];
            state_nxt = B_READ;
          end else begin
            rem_nxt   = '0;
            rstep_nxt = '0;
            state_nxt = B_REDUCE;
          end
        end
      end
      B_REDUCE: begin
        rstep_nxt = rstep_r + 4'd1;
        if (!rstep_r[0]) begin
          tq_nxt = t_cur;
          q_nxt  = t_prod[39:32];
        end else begin
          rem_nxt = (t_rem >= DEPTH_T) ? AW'(t_rem - DEPTH_T) : AW'(t_rem);
          if (rstep_r == 4'd15) begin
            bkt_nxt   = rem_nxt;
            state_nxt = B_READ;
          end
        end
      end
      B_READ: begin
        mem_re    = 1'b1;
        state_nxt = B_CHECK;
      end
      B_CHECK: begin
        if (!rd_q.valid) begin
          mem_we    = 1'b1;
          mem_wd    = '{1'b1, hash_r, COUNT_BITS'(1)};
          uniq_nxt  = uniq_r + 17'd1;
          ov_nxt    = 1'b1;
          out_nxt   = '{ST_NEW, hash_r, 32'd1, uniq_nxt};
          state_nxt = B_IDLE;
        end else if (rd_q.key == hash_r) begin
          mem_we    = 1'b1;
          mem_wd    = '{1'b1, hash_r, cnt_inc};
          ov_nxt    = 1'b1;
          out_nxt   = '{ST_INCR, hash_r, 32'(cnt_inc), uniq_r};
          state_nxt = B_IDLE;
        end else if (probe_r == PW'(PROBE_LIMIT - 1)) begin
          ov_nxt    = 1'b1;
          out_nxt   = '{ST_DROPPED, hash_r, '0, uniq_r};
          state_nxt = B_IDLE;
        end else begin
          probe_nxt = probe_r + 1'b1;
          bkt_nxt   = (bkt_r == LAST) ? '0 : bkt_r + 1'b1;
          state_nxt = B_READ;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      bkt_r   <= '0;
      uniq_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bkt_r   <= bkt_nxt;
      uniq_r  <= uniq_nxt;
      ov_r    <= ov_nxt;
    end
    hash_r  <= hash_nxt;
    rem_r   <= rem_nxt;
    rstep_r <= rstep_nxt;
    tq_r    <= tq_nxt;
    q_r     <= q_nxt;
    probe_r <= probe_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[bkt_r];
  end

  assign clearing  = (state_r == B_CLEAR);
  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/ckhc_checker.sv
`include "canonical_kmer_hash_counter_assert.svh"

module ckhc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input ckhc_pkg::out_t out_data
);
  import ckhc_pkg::*;

  `CKHC_ASSERT_IMP(a_none_zero, clk, rst_n, out_valid && out_data.status == ST_NONE, out_data.kmer_hash == '0 && out_data.hit_count == '0)
  `CKHC_ASSERT_IMP(a_new_one, clk, rst_n, out_valid && out_data.status == ST_NEW, out_data.hit_count == 32'd1 && out_data.unique_count != '0)
  `CKHC_ASSERT_IMP(a_drop_zero, clk, rst_n, out_valid && out_data.status == ST_DROPPED, out_data.hit_count == '0)
  `CKHC_ASSERT_NEXT(a_reset_quiet, clk, !rst_n, !out_valid)

endmodule

bind canonical_kmer_hash_counter ckhc_checker u_ckhc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_data  (out_data)
);
